// File: rtl/assert_macros.svh
// Assertion macros used by the dispatcher back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define RGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define RGD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RGD_ASSERT(lbl, prop, msg)
`define RGD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/rgd_pkg.sv
// Types, codes and defaults of the grouped request dispatcher.
`timescale 1ns / 1ps
package rgd_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned GROUP_BITS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_LIMIT = 1'b1;

  localparam logic [6:0]  QUEUE_LIMIT_RST = 7'd64;
  localparam logic [15:0] AGING_LIMIT_RST = 16'd8;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_CLOSED = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DISP  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] tag;
    logic [7:0]  grp;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: rtl/rgd_if.sv
// Request and response channel interfaces of the dispatcher.
`timescale 1ns / 1ps
interface rgd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] request_tag;
  logic [7:0]  group_id;
  modport source (output valid, operation, request_tag, group_id, input ready);
  modport sink (input valid, operation, request_tag, group_id, output ready);
endinterface

interface rgd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_tag;
  logic [7:0]  served_group;
  logic        was_starved;
  logic        was_reordered;
  logic [6:0]  occupancy;
  logic [31:0] reorder_total;
  logic [31:0] starve_total;
  modport source (output valid, status, served_tag, served_group, was_starved,
                  was_reordered, occupancy, reorder_total, starve_total, input ready);
  modport sink (input valid, status, served_tag, served_group, was_starved,
                was_reordered, occupancy, reorder_total, starve_total, output ready);
endinterface

// File: rtl/rgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/rgd_front.sv
// Front end: accepts items, decodes the operation and queues commands.
`timescale 1ns / 1ps
module rgd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgd_req_if.sink       req_i,
  output rgd_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i
);
  import rgd_pkg::*;

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.tag = req_i.request_tag;
    cmd_in.grp = req_i.group_id;
    unique case (req_i.operation)
      OP_ENQ:   cmd_in.op = OP_ENQ;
      OP_DISP:  cmd_in.op = OP_DISP;
      OP_CLOSE: cmd_in.op = OP_CLOSE;
      default:  cmd_in.op = OP_NONE;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(cmd_pop_i && cmd_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i && cmd_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i && cmd_valid_o) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end
endmodule

// File: rtl/rgd_back.sv
// Back end: slot table, group counts, scans and the response register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgd_back #(
  parameter int unsigned SLOTS      = rgd_pkg::SLOTS_DEF,
  parameter int unsigned GROUP_BITS = rgd_pkg::GROUP_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rgd_pkg::cfg_wr_t cfg_i,
  input  rgd_pkg::cmd_t   cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  rgd_rsp_if.source       rsp_o
);
  import rgd_pkg::*;

  localparam int unsigned GB    = GROUP_BITS;
  localparam int unsigned GD    = 1 << GB;
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned LW    = (CW > 7) ? CW : 7;
  localparam int unsigned CLR_N = (SLOTS > GD) ? SLOTS : GD;
  localparam int unsigned CLW   = $clog2(CLR_N) + 1;
  localparam int unsigned RW    = 97 + GB;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ESCAN = 3'd2;
  localparam logic [2:0] S_DSCAN = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_CWR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CLW-1:0] clr_q, clr_d;
  logic [CW-1:0] held_q, held_d;
  logic [63:0]   order_q, order_d;
  logic          closed_q, closed_d;
  logic [31:0]   reo_q, reo_d, stv_q, stv_d;
  logic [6:0]    qlim_q;
  logic [15:0]   alim_q;

  // Scan pipeline: stage 1 sees slot data, stage 2 sees the group count.
  logic [IW:0]   ra_q, ra_d;
  logic          p1_v_q, p1_v_d;
  logic [IW-1:0] p1_idx_q, p1_idx_d;
  logic          p2_v_q, p2_v_d;
  logic [IW-1:0] p2_idx_q, p2_idx_d;
  logic [63:0]   p2_ord_q, p2_ord_d;
  logic [15:0]   p2_tag_q, p2_tag_d;
  logic [GB-1:0] p2_grp_q, p2_grp_d;

  logic [15:0]   ctag_q, ctag_d;
  logic [GB-1:0] cgrp_q, cgrp_d;
  logic          isdisp_q, isdisp_d;

  logic          old_v_q, old_v_d;
  logic [63:0]   old_q, old_d;
  logic          st_v_q, st_v_d;
  logic [IW-1:0] st_idx_q, st_idx_d;
  logic [63:0]   st_ord_q, st_ord_d;
  logic [15:0]   st_tag_q, st_tag_d;
  logic [GB-1:0] st_grp_q, st_grp_d;
  logic          gb_v_q, gb_v_d;
  logic [CW-1:0] gb_n_q, gb_n_d;
  logic [IW-1:0] gb_idx_q, gb_idx_d;
  logic [63:0]   gb_ord_q, gb_ord_d;
  logic [15:0]   gb_tag_q, gb_tag_d;
  logic [GB-1:0] gb_grp_q, gb_grp_d;

  logic [IW-1:0] pk_idx_q, pk_idx_d;
  logic [15:0]   pk_tag_q, pk_tag_d;
  logic          pk_st_q, pk_st_d;
  logic          pk_reo_q, pk_reo_d;

  logic        out_v_q, out_v_d;
  logic [1:0]  o_stat_q, o_stat_d;
  logic [15:0] o_tag_q, o_tag_d;
  logic [7:0]  o_grp_q, o_grp_d;
  logic        o_st_q, o_st_d, o_reo_q, o_reo_d;
  logic [6:0]  o_occ_q, o_occ_d;

  logic          s_we;
  logic [IW-1:0] s_wa, s_ra;
  logic [RW-1:0] s_wd, s_rd;
  logic          c_we;
  logic [GB-1:0] c_wa, c_ra;
  logic [CW-1:0] c_wd, c_rd;

  logic          r_valid;
  logic [GB-1:0] r_grp;
  logic [15:0]   r_tag;
  logic [63:0]   r_ord;
  logic [15:0]   r_skip;
  logic [LW-1:0] limit;
  logic          out_free, scan_done;
  logic [GB-1:0] cmd_grp;

  assign r_valid = s_rd[96+GB];
  assign r_grp   = s_rd[96 +: GB];
  assign r_tag   = s_rd[95:80];
  assign r_ord   = s_rd[79:16];
  assign r_skip  = s_rd[15:0];
  assign cmd_grp = GB'(cmd_i.grp);

  assign limit = (LW'(qlim_q) < LW'(SLOTS)) ? LW'(qlim_q) : LW'(SLOTS);
  assign out_free  = !out_v_q || rsp_o.ready;
  assign scan_done = (ra_q == (IW+1)'(SLOTS)) && !p1_v_q && !p2_v_q;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && out_free;

  rgd_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );
  rgd_ram #(.WIDTH(CW), .DEPTH(GD)) u_count_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd)
  );

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  held_d = held_q;  order_d = order_q;
    closed_d = closed_q;  reo_d = reo_q;  stv_d = stv_q;
    ra_d = ra_q;  p1_v_d = 1'b0;  p1_idx_d = p1_idx_q;
    p2_v_d = 1'b0;  p2_idx_d = p2_idx_q;  p2_ord_d = p2_ord_q;
    p2_tag_d = p2_tag_q;  p2_grp_d = p2_grp_q;
    ctag_d = ctag_q;  cgrp_d = cgrp_q;  isdisp_d = isdisp_q;
    old_v_d = old_v_q;  old_d = old_q;
    st_v_d = st_v_q;  st_idx_d = st_idx_q;  st_ord_d = st_ord_q;
    st_tag_d = st_tag_q;  st_grp_d = st_grp_q;
    gb_v_d = gb_v_q;  gb_n_d = gb_n_q;  gb_idx_d = gb_idx_q;  gb_ord_d = gb_ord_q;
    gb_tag_d = gb_tag_q;  gb_grp_d = gb_grp_q;
    pk_idx_d = pk_idx_q;  pk_tag_d = pk_tag_q;  pk_st_d = pk_st_q;  pk_reo_d = pk_reo_q;
    out_v_d = out_v_q && !rsp_o.ready;
    o_stat_d = o_stat_q;  o_tag_d = o_tag_q;  o_grp_d = o_grp_q;
    o_st_d = o_st_q;  o_reo_d = o_reo_q;  o_occ_d = o_occ_q;
    s_we = 1'b0;  s_wa = p1_idx_q;  s_wd = '0;  s_ra = ra_q[IW-1:0];
    c_we = 1'b0;  c_wa = cgrp_q;  c_wd = '0;  c_ra = cgrp_q;

    unique case (state_q)
      S_CLEAR: begin
        s_wa = clr_q[IW-1:0];
        s_we = (clr_q < CLW'(SLOTS));
        c_wa = clr_q[GB-1:0];
        c_we = (clr_q < CLW'(GD));
        clr_d = clr_q + CLW'(1);
        if (clr_q == CLW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_pop_o) begin
          o_tag_d = '0;  o_grp_d = '0;  o_st_d = 1'b0;  o_reo_d = 1'b0;
          o_stat_d = STAT_OK;
          o_occ_d  = 7'(held_q);
          ctag_d = cmd_i.tag;  cgrp_d = cmd_grp;
          isdisp_d = (cmd_i.op == OP_DISP);
          ra_d = '0;  old_v_d = 1'b0;  st_v_d = 1'b0;  gb_v_d = 1'b0;
          unique case (cmd_i.op)
            OP_ENQ: begin
              if (closed_q) begin
                o_stat_d = STAT_CLOSED;  out_v_d = 1'b1;
              end else if (LW'(held_q) >= limit) begin
                o_stat_d = STAT_FULL;  out_v_d = 1'b1;
              end else begin
                state_d = S_ESCAN;
              end
            end
            OP_DISP: begin
              if (held_q == '0) begin
                o_stat_d = STAT_EMPTY;  out_v_d = 1'b1;
              end else begin
                state_d = S_DSCAN;
              end
            end
            OP_CLOSE: begin
              closed_d = 1'b1;  out_v_d = 1'b1;
            end
            default: out_v_d = 1'b1;
          endcase
        end
      end
      S_ESCAN: begin
        if (ra_q != (IW+1)'(SLOTS)) begin
          ra_d = ra_q + (IW+1)'(1);  p1_v_d = 1'b1;  p1_idx_d = ra_q[IW-1:0];
        end
        // Take the lowest free slot; later reads in flight are dropped.
        if (p1_v_q && !r_valid) begin
          s_we = 1'b1;
          s_wd = {1'b1, cgrp_q, ctag_q, order_q, 16'd0};
          order_d = order_q + 64'd1;
          held_d  = held_q + CW'(1);
          p1_v_d  = 1'b0;
          state_d = S_CWR;
        end else if (!p1_v_q && ra_q == (IW+1)'(SLOTS)) begin
          o_stat_d = STAT_FULL;
          state_d  = S_FIN;
        end
      end
      S_DSCAN: begin
        if (ra_q != (IW+1)'(SLOTS)) begin
          ra_d = ra_q + (IW+1)'(1);  p1_v_d = 1'b1;  p1_idx_d = ra_q[IW-1:0];
        end
        if (p1_v_q && r_valid) begin
          if (!old_v_q || r_ord < old_q) begin
            old_v_d = 1'b1;  old_d = r_ord;
          end
          if (r_skip >= alim_q && (!st_v_q || r_ord < st_ord_q)) begin
            st_v_d = 1'b1;  st_idx_d = p1_idx_q;  st_ord_d = r_ord;
            st_tag_d = r_tag;  st_grp_d = r_grp;
          end
          c_ra = r_grp;
          p2_v_d = 1'b1;  p2_idx_d = p1_idx_q;  p2_ord_d = r_ord;
          p2_tag_d = r_tag;  p2_grp_d = r_grp;
        end
        if (p2_v_q && (!gb_v_q || c_rd > gb_n_q || (c_rd == gb_n_q && p2_ord_q < gb_ord_q)))
        begin
          gb_v_d = 1'b1;  gb_n_d = c_rd;  gb_idx_d = p2_idx_q;  gb_ord_d = p2_ord_q;
          gb_tag_d = p2_tag_q;  gb_grp_d = p2_grp_q;
        end
        if (scan_done) begin
          pk_st_d = st_v_q;
          if (st_v_q) begin
            pk_idx_d = st_idx_q;  pk_tag_d = st_tag_q;  cgrp_d = st_grp_q;
            pk_reo_d = (st_ord_q != old_q);
          end else begin
            pk_idx_d = gb_idx_q;  pk_tag_d = gb_tag_q;  cgrp_d = gb_grp_q;
            pk_reo_d = (gb_ord_q != old_q);
          end
          if ((st_v_q ? (st_ord_q != old_q) : (gb_ord_q != old_q)) && reo_q != '1) begin
            reo_d = reo_q + 32'd1;
          end
          if (st_v_q && stv_q != '1) begin
            stv_d = stv_q + 32'd1;
          end
          held_d  = held_q - CW'(1);
          ra_d    = '0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (ra_q != (IW+1)'(SLOTS)) begin
          ra_d = ra_q + (IW+1)'(1);  p1_v_d = 1'b1;  p1_idx_d = ra_q[IW-1:0];
        end
        // Retire the served slot, age every other held slot.
        if (p1_v_q && r_valid) begin
          s_we = 1'b1;
          s_wd = {(p1_idx_q != pk_idx_q), r_grp, r_tag, r_ord,
                  (r_skip != 16'hFFFF) ? r_skip + 16'd1 : r_skip};
        end
        if (!p1_v_q && ra_q == (IW+1)'(SLOTS)) begin
          state_d = S_CWR;
        end
      end
      S_CWR: begin
        c_we = 1'b1;
        c_wd = isdisp_q ? c_rd - CW'(1) : c_rd + CW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_v_d  = 1'b1;
          o_occ_d  = 7'(held_q);
          o_tag_d  = isdisp_q ? pk_tag_q : 16'd0;
          o_grp_d  = isdisp_q ? 8'(cgrp_q) : 8'd0;
          o_st_d   = isdisp_q && pk_st_q;
          o_reo_d  = isdisp_q && pk_reo_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      held_q   <= '0;
      order_q  <= '0;
      closed_q <= 1'b0;
      reo_q    <= '0;
      stv_q    <= '0;
      qlim_q   <= QUEUE_LIMIT_RST;
      alim_q   <= AGING_LIMIT_RST;
      ra_q     <= '0;
      p1_v_q   <= 1'b0;
      p2_v_q   <= 1'b0;
      old_v_q  <= 1'b0;
      st_v_q   <= 1'b0;
      gb_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      held_q   <= held_d;
      order_q  <= order_d;
      closed_q <= closed_d;
      reo_q    <= reo_d;
      stv_q    <= stv_d;
      ra_q     <= ra_d;
      p1_v_q   <= p1_v_d;
      p2_v_q   <= p2_v_d;
      old_v_q  <= old_v_d;
      st_v_q   <= st_v_d;
      gb_v_q   <= gb_v_d;
      out_v_q  <= out_v_d;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          CFG_QUEUE_LIMIT: qlim_q <= cfg_i.data[6:0];
          CFG_AGING_LIMIT: alim_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q <= p1_idx_d;  p2_idx_q <= p2_idx_d;  p2_ord_q <= p2_ord_d;
    p2_tag_q <= p2_tag_d;  p2_grp_q <= p2_grp_d;
    ctag_q <= ctag_d;  cgrp_q <= cgrp_d;  isdisp_q <= isdisp_d;
    old_q <= old_d;
    st_idx_q <= st_idx_d;  st_ord_q <= st_ord_d;  st_tag_q <= st_tag_d;  st_grp_q <= st_grp_d;
    gb_n_q <= gb_n_d;  gb_idx_q <= gb_idx_d;  gb_ord_q <= gb_ord_d;
    gb_tag_q <= gb_tag_d;  gb_grp_q <= gb_grp_d;
    pk_idx_q <= pk_idx_d;  pk_tag_q <= pk_tag_d;  pk_st_q <= pk_st_d;  pk_reo_q <= pk_reo_d;
    o_stat_q <= o_stat_d;  o_tag_q <= o_tag_d;  o_grp_q <= o_grp_d;
    o_st_q <= o_st_d;  o_reo_q <= o_reo_d;  o_occ_q <= o_occ_d;
  end

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.status        = o_stat_q;
  assign rsp_o.served_tag    = o_tag_q;
  assign rsp_o.served_group  = o_grp_q;
  assign rsp_o.was_starved   = o_st_q;
  assign rsp_o.was_reordered = o_reo_q;
  assign rsp_o.occupancy     = o_occ_q;
  assign rsp_o.reorder_total = reo_q;
  assign rsp_o.starve_total  = stv_q;

  `RGD_ASSERT(a_held_max, held_q <= CW'(SLOTS), "held count above slot count")
  `RGD_ASSERT(a_no_pop_clear, state_q == S_CLEAR |-> !cmd_pop_o, "item popped while clearing")
  `RGD_ASSERT(a_starve_mono, stv_q >= $past(stv_q), "starvation total went down")
  `RGD_ASSERT(a_disp_dec, state_q == S_DSCAN && scan_done |=> held_q == CW'($past(held_q) - CW'(1)), "dispatch did not drop one entry")
  `RGD_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> state_q == S_CLEAR, "reset did not start clearing")
endmodule

// File: rtl/grouped_request_dispatcher_with_aging_unit.sv
// Top level of the grouped request dispatcher with aging.
//
//  channel | dir | handshake        | content
//  req_i   | in  | valid/ready      | operation, request_tag, group_id
//  rsp_o   | out | valid/ready      | status, tag, group, flags, occupancy, totals
//  cfg     | in  | cfg_we_i         | cfg_idx_i selects queue_limit or aging_limit
//
// Close, refused and empty items are answered straight from the idle state. Enqueue scans
// the slot RAM for the lowest free slot. Dispatch makes two passes over the slot RAM
// (select, then age and retire).
// After reset a clearing pass over the slot and group count RAMs runs before the first item.
// A two-entry command queue takes items while the back end works or the response stalls, until full.
`timescale 1ns / 1ps
module grouped_request_dispatcher_with_aging_unit #(
  parameter int unsigned SLOTS      = rgd_pkg::SLOTS_DEF,
  parameter int unsigned GROUP_BITS = rgd_pkg::GROUP_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rgd_req_if.sink                          req_i,
  rgd_rsp_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rgd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rgd_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  rgd_front u_front (
    .clk_i, .rst_ni, .req_i, .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  rgd_back #(.SLOTS(SLOTS), .GROUP_BITS(GROUP_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_pop_o(cmd_pop), .rsp_o
  );
endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the grouped request dispatcher with aging.
`timescale 1ns / 1ps
module tb_top;
  import rgd_pkg::*;

  localparam int NSLOT      = 64;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_WAIT = 2 * NSLOT + 20;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [7:0]  grp;
    logic        starved;
    logic        reordered;
    logic [6:0]  occ;
    logic [31:0] reorders;
    logic [31:0] starves;
  } disp_rsp_t;

  typedef struct {
    op_e         op;
    logic [15:0] tag;
    logic [7:0]  grp;
    bit          fixed;
    disp_rsp_t   rsp;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rgd_req_if req ();
  rgd_rsp_if rsp ();

  grouped_request_dispatcher_with_aging_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Scoreboard state and the dispatcher mirror.
  disp_rsp_t   pending_rsp[$];
  int          errors;
  bit          hold_req;
  logic [6:0]  lim_queue;
  logic [15:0] lim_aging;
  bit          s_valid[NSLOT];
  logic [7:0]  s_grp[NSLOT];
  logic [15:0] s_tag[NSLOT];
  longint unsigned s_seq[NSLOT];
  logic [15:0] s_skips[NSLOT];
  int          held;
  longint unsigned next_seq;
  bit          is_closed;
  logic [31:0] reorder_cnt, starve_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int members(logic [7:0] g);
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (s_valid[i] && s_grp[i] == g) n++;
    return n;
  endfunction

  function automatic disp_rsp_t dispatch_next();
    disp_rsp_t r;
    int pick, best_n, n;
    bit starved;
    longint unsigned oldest;
    r = '{default: '0};
    pick = -1;
    starved = 0;
    oldest = '1;
    if (held == 0) begin
      r.status = STAT_EMPTY;
      return r;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (!s_valid[i]) continue;
      if (s_seq[i] < oldest) oldest = s_seq[i];
      if (s_skips[i] >= lim_aging && (pick < 0 || s_seq[i] < s_seq[pick])) pick = i;
    end
    if (pick >= 0) begin
      starved = 1;
    end else begin
      best_n = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!s_valid[i]) continue;
        n = members(s_grp[i]);
        if (pick < 0 || n > best_n || (n == best_n && s_seq[i] < s_seq[pick]) ||
            (n == best_n && s_seq[i] == s_seq[pick] && s_grp[i] < s_grp[pick])) begin
          pick = i;
          best_n = n;
        end
      end
    end
    s_valid[pick] = 0;
    held--;
    r.status    = STAT_OK;
    r.tag       = s_tag[pick];
    r.grp       = s_grp[pick];
    r.starved   = starved;
    r.reordered = (s_seq[pick] != oldest);
    if (r.reordered && reorder_cnt != '1) reorder_cnt++;
    if (starved && starve_cnt != '1) starve_cnt++;
    // Age every entry left behind.
    for (int i = 0; i < NSLOT; i++)
      if (s_valid[i] && s_skips[i] != '1) s_skips[i]++;
    return r;
  endfunction

  function automatic disp_rsp_t predict_dispatch(op_e op, logic [15:0] tag, logic [7:0] grp);
    disp_rsp_t r;
    int cap;
    r = '{default: '0};
    cap = (lim_queue < NSLOT) ? lim_queue : NSLOT;
    case (op)
      OP_ENQ: begin
        if (is_closed) r.status = STAT_CLOSED;
        else if (held >= cap) r.status = STAT_FULL;
        else begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!s_valid[i]) begin
              s_valid[i] = 1;
              s_tag[i]   = tag;
              s_grp[i]   = grp;
              s_seq[i]   = next_seq;
              s_skips[i] = '0;
              next_seq++;
              held++;
              break;
            end
          end
          r.status = STAT_OK;
        end
      end
      OP_DISP: r = dispatch_next();
      OP_CLOSE: is_closed = 1;
      default: ;
    endcase
    r.occ      = held[6:0];
    r.reorders = reorder_cnt;
    r.starves  = starve_cnt;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Receiver: check each accepted item, stall on its own pattern.
  initial begin
    disp_rsp_t e;
    int mode, hold_left;
    rsp.ready <= 1'b0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          report("unexpected item", 32'(rsp.status), 32'd0);
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.status !== e.status) report("status", 32'(rsp.status), 32'(e.status));
          if (rsp.served_tag !== e.tag)
            report("served_tag", 32'(rsp.served_tag), 32'(e.tag));
          if (rsp.served_group !== e.grp)
            report("served_group", 32'(rsp.served_group), 32'(e.grp));
          if (rsp.was_starved !== e.starved)
            report("was_starved", 32'(rsp.was_starved), 32'(e.starved));
          if (rsp.was_reordered !== e.reordered)
            report("was_reordered", 32'(rsp.was_reordered), 32'(e.reordered));
          if (rsp.occupancy !== e.occ) report("occupancy", 32'(rsp.occupancy), 32'(e.occ));
          if (rsp.reorder_total !== e.reorders)
            report("reorder_total", rsp.reorder_total, e.reorders);
          if (rsp.starve_total !== e.starves)
            report("starve_total", rsp.starve_total, e.starves);
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 0;
        hold_left = HOLD_LEN;
      end
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (mode == 0) rsp.ready <= 1'b1;
      else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
      else rsp.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  int burst_left;

  task automatic send(op_e op, logic [15:0] tag, logic [7:0] grp, bit fixed, disp_rsp_t want);
    disp_rsp_t p;
    int gap;
    req.valid       <= 1'b1;
    req.operation   <= op;
    req.request_tag <= tag;
    req.group_id    <= grp;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    p = predict_dispatch(op, tag, grp);
    pending_rsp = {pending_rsp, (fixed ? want : p)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_QUEUE_LIMIT) lim_queue = val[6:0];
    else lim_aging = val;
  endtask

  task automatic run_random(int count);
    op_e op;
    int r, enq_pct;
    logic [7:0] g;
    for (int k = 0; k < count; k++) begin
      enq_pct = ((k / 40) % 2) ? 35 : 70;
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_NONE;
      else if (r < 2 + enq_pct) op = OP_ENQ;
      else op = OP_DISP;
      g = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      send(op, 16'($urandom), g, 0, '{default: '0});
    end
  endtask

  stim_row_t opening[] = '{
    '{OP_DISP, 16'h0, 8'h0, 1, '{STAT_EMPTY, 16'h0, 8'h0, 0, 0, 7'd0, 32'd0, 32'd0}},
    '{OP_NONE, 16'h0, 8'h0, 1, '{STAT_OK, 16'h0, 8'h0, 0, 0, 7'd0, 32'd0, 32'd0}},
    '{OP_ENQ, 16'h0000, 8'h00, 1, '{STAT_OK, 16'h0, 8'h0, 0, 0, 7'd1, 32'd0, 32'd0}},
    '{OP_ENQ, 16'hffff, 8'hff, 1, '{STAT_OK, 16'h0, 8'h0, 0, 0, 7'd2, 32'd0, 32'd0}},
    '{OP_ENQ, 16'h1111, 8'h01, 0, '{default: '0}},
    '{OP_ENQ, 16'h2222, 8'h01, 0, '{default: '0}},
    '{OP_ENQ, 16'h3333, 8'h01, 0, '{default: '0}},
    '{OP_ENQ, 16'h4444, 8'h00, 0, '{default: '0}},
    '{OP_ENQ, 16'h5555, 8'haa, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_ENQ, 16'h6666, 8'h55, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_DISP, 16'h0, 8'h0, 0, '{default: '0}}
  };

  stim_row_t closing[] = '{
    '{OP_ENQ, 16'h7777, 8'h07, 0, '{default: '0}},
    '{OP_CLOSE, 16'h0, 8'h0, 0, '{default: '0}},
    '{OP_ENQ, 16'h8888, 8'h08, 0, '{default: '0}},
    '{OP_CLOSE, 16'h0, 8'h0, 0, '{default: '0}}
  };

  int unsigned q_lims[] = '{1, 4, 64, 33, 0, 64, 64};
  int unsigned a_lims[] = '{1, 0, 65535, 3, 5, 2, 1};

  initial begin
    errors = 0;
    hold_req = 0;
    burst_left = 0;
    lim_queue = QUEUE_LIMIT_RST;
    lim_aging = AGING_LIMIT_RST;
    for (int i = 0; i < NSLOT; i++) begin
      s_valid[i] = 0;
      s_grp[i] = '0;
      s_tag[i] = '0;
      s_seq[i] = 0;
      s_skips[i] = '0;
    end
    held = 0;
    next_seq = 0;
    is_closed = 0;
    reorder_cnt = '0;
    starve_cnt = '0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_QUEUE_LIMIT;
    cfg_data_i      <= '0;
    req.valid       <= 1'b0;
    req.operation   <= OP_NONE;
    req.request_tag <= '0;
    req.group_id    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send(opening[i].op, opening[i].tag, opening[i].grp,
                              opening[i].fixed, opening[i].rsp);
    // Long receiver hold while items keep coming, to back up the input.
    hold_req = 1;
    run_random(370);
    wait_drained();
    foreach (q_lims[p]) begin
      write_reg(CFG_QUEUE_LIMIT, 16'(q_lims[p]));
      write_reg(CFG_AGING_LIMIT, 16'(a_lims[p]));
      run_random(q_lims[p] == 0 ? 60 : 210);
      wait_drained();
    end
    // Close for good, then drain what is held.
    foreach (closing[i]) send(closing[i].op, closing[i].tag, closing[i].grp,
                              closing[i].fixed, closing[i].rsp);
    while (held > 0) send(OP_DISP, 16'h0, 8'h0, 0, '{default: '0});
    send(OP_DISP, 16'h0, 8'h0, 0, '{default: '0});
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
